// ----- rtl/bmf_pkg.sv -----
// Shared types and constants for the 3x3 box mean filter.
`default_nettype none
package bmf_pkg;

    localparam int PIX_W   = 8;
    localparam int CFG_W   = 9;
    localparam int MEAN_W  = 12;
    localparam int COORD_W = 8;
    localparam int SUM_W   = 12;
    localparam int COL_W   = 10;

    localparam logic [CFG_W-1:0] CFG_SIZE_RESET = 9'd256;

    // Register indexes of the configuration port.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // floor(x / 9) == (x * MEAN_RECIP) >> MEAN_SHIFT for every x below 74898.
    localparam logic [15:0] MEAN_RECIP = 16'd58255;
    localparam int          MEAN_SHIFT = 19;

    typedef struct packed {
        logic               win;
        logic               last;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_meta;

endpackage
`default_nettype wire

// ----- rtl/bmf_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module bmf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/bmf_raster.sv -----
// Frame size registers and raster position counters.
`default_nettype none
module bmf_raster
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_we,
    input  wire logic                         i_cfg_index,
    input  wire logic [CFG_W-1:0]             i_cfg_data,
    input  wire logic                         i_advance,
    output logic      [$clog2(MAX_WIDTH)-1:0] o_col,
    output t_meta                             o_meta
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int EW0 = (CW > RW) ? CW : RW;
    localparam int EW  = ((EW0 > CFG_W) ? EW0 : CFG_W) + 1;

    logic [CFG_W-1:0] r_frame_width;
    logic [CFG_W-1:0] r_frame_height;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [CW-1:0]    n_col;
    logic [RW-1:0]    n_row;
    logic [EW-1:0]    col_ext;
    logic [EW-1:0]    row_ext;
    logic [EW-1:0]    fw_ext;
    logic [EW-1:0]    fh_ext;
    logic [EW-1:0]    w_last;
    logic [EW-1:0]    h_last;
    logic             col_end;
    logic             row_end;

    assign col_ext = EW'(r_col);
    assign row_ext = EW'(r_row);
    assign fw_ext  = EW'(r_frame_width);
    assign fh_ext  = EW'(r_frame_height);

    always_comb begin
        if (fw_ext < EW'(3)) begin
            w_last = EW'(2);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            w_last = EW'(MAX_WIDTH - 1);
        end else begin
            w_last = fw_ext - EW'(1);
        end
        if (fh_ext < EW'(3)) begin
            h_last = EW'(2);
        end else if (fh_ext > EW'(MAX_HEIGHT)) begin
            h_last = EW'(MAX_HEIGHT - 1);
        end else begin
            h_last = fh_ext - EW'(1);
        end
    end

    assign col_end = (col_ext == w_last);
    assign row_end = (row_ext == h_last);

    always_comb begin
        n_col = r_col + CW'(1);
        n_row = r_row;
        if (col_end) begin
            n_col = '0;
            n_row = row_end ? '0 : r_row + RW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= CFG_SIZE_RESET;
            r_frame_height <= CFG_SIZE_RESET;
            r_col          <= '0;
            r_row          <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data;
                end
                default: begin
                end
            endcase
            r_col <= '0;
            r_row <= '0;
        end else if (i_advance) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_col       = r_col;
    assign o_meta.win  = (row_ext >= EW'(2)) && (col_ext >= EW'(2));
    assign o_meta.last = row_end && col_end;
    assign o_meta.row  = COORD_W'(row_ext - EW'(2));
    assign o_meta.col  = COORD_W'(col_ext - EW'(2));

    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_col == '0) && (r_row == '0))
        else $error("frame position not cleared by a configuration write");

    a_col_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        col_ext <= w_last)
        else $error("column counter beyond the row end");

    a_row_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        row_ext <= h_last)
        else $error("row counter beyond the frame end");

endmodule
`default_nettype wire

// ----- rtl/bmf_scale.sv -----
// Window sum to 8.4 mean by reciprocal multiplication, one register stage.
`default_nettype none
module bmf_scale
    import bmf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire logic              i_valid,
    input  wire logic [SUM_W-1:0]  i_sum,
    input  wire t_meta             i_meta,
    output logic                   o_valid,
    output logic      [MEAN_W-1:0] o_mean,
    output t_meta                  o_meta
);

    logic [15:0] sum_x16;
    logic [31:0] product;
    logic        r_valid;
    logic [31:0] r_product;
    t_meta       r_meta;

    assign sum_x16 = {i_sum, 4'b0000};
    assign product = 32'(sum_x16) * 32'(MEAN_RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_product <= product;
            r_meta    <= i_meta;
        end
    end

    assign o_valid = r_valid;
    assign o_mean  = r_product[MEAN_SHIFT +: MEAN_W];
    assign o_meta  = r_meta;

endmodule
`default_nettype wire

// ----- rtl/box_mean_filter_3x3.sv -----
// Top level of the streaming 3x3 box mean filter with line-store RAM.
// An accepted word passes the input stage, the window sum register, the scale register and the output register.
// Throughput: one pixel per cycle; the pipeline moves when the output register is empty or read.
// Windows need no RAM forwarding: the line-store address repeats only every row width.
// Reset clears the counters, window columns and valid flags; sizes return to 256 by 256.
// Line-store RAM has no reset and no clearing pass; every entry is written before use.
`default_nettype none
module box_mean_filter_3x3
    import bmf_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             s_axis_tvalid,
    output logic                  s_axis_tready,
    input  wire logic [7:0]       s_axis_tdata,   // pixel
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic      [31:0]      m_axis_tdata,   // mean_value, window_row, window_col, zero fill
    output logic                  m_axis_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic               en;
    logic               accept;
    logic [CW-1:0]      scan_col;
    t_meta              scan_meta;
    logic [2*PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0]   top_px;
    logic [PIX_W-1:0]   mid_px;
    logic [COL_W-1:0]   col_sum;
    logic [SUM_W-1:0]   win_sum;

    logic               r_s1_valid;
    logic [PIX_W-1:0]   r_s1_px;
    logic [CW-1:0]      r_s1_addr;
    t_meta              r_s1_meta;
    logic [COL_W-1:0]   r_col1;
    logic [COL_W-1:0]   r_col2;
    logic               r_s2_valid;
    logic [SUM_W-1:0]   r_s2_sum;
    t_meta              r_s2_meta;
    logic               s3_valid;
    logic [MEAN_W-1:0]  s3_mean;
    t_meta              s3_meta;
    logic               r_out_valid;
    logic [MEAN_W-1:0]  r_out_mean;
    t_meta              r_out_meta;

    assign en     = !r_out_valid || m_axis_tready;
    assign accept = s_axis_tvalid && en;

    bmf_raster #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HEIGHT(MAX_HEIGHT)
    ) u_raster (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_advance  (accept),
        .o_col      (scan_col),
        .o_meta     (scan_meta)
    );

    // Each entry holds the upper line in the high byte and the middle line in the low byte.
    bmf_ram #(
        .WIDTH(2 * PIX_W),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .i_clk  (i_clk),
        .i_we   (r_s1_valid),
        .i_waddr(r_s1_addr),
        .i_wdata({mid_px, r_s1_px}),
        .i_re   (accept),
        .i_raddr(scan_col),
        .o_rdata(ram_rdata)
    );

    assign top_px  = ram_rdata[2*PIX_W-1:PIX_W];
    assign mid_px  = ram_rdata[PIX_W-1:0];
    assign col_sum = COL_W'(top_px) + COL_W'(mid_px) + COL_W'(r_s1_px);
    assign win_sum = SUM_W'(col_sum) + SUM_W'(r_col1) + SUM_W'(r_col2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_col1      <= '0;
            r_col2      <= '0;
        end else begin
            if (en) begin
                r_s1_valid  <= accept;
                r_s2_valid  <= r_s1_valid;
                r_out_valid <= s3_valid && s3_meta.win;
            end
            if (i_cfg_we) begin
                r_col1 <= '0;
                r_col2 <= '0;
            end else if (en && r_s1_valid) begin
                r_col1 <= col_sum;
                r_col2 <= r_col1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_px   <= s_axis_tdata;
            r_s1_addr <= scan_col;
            r_s1_meta <= scan_meta;
        end
        if (en) begin
            r_s2_sum   <= win_sum;
            r_s2_meta  <= r_s1_meta;
            r_out_mean <= s3_mean;
            r_out_meta <= s3_meta;
        end
    end

    bmf_scale u_scale (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(r_s2_valid),
        .i_sum  (r_s2_sum),
        .i_meta (r_s2_meta),
        .o_valid(s3_valid),
        .o_mean (s3_mean),
        .o_meta (s3_meta)
    );

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_meta.col, r_out_meta.row, r_out_mean};
    assign m_axis_tlast  = r_out_meta.last;

    a_no_ram_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && r_s1_valid) |-> (scan_col != r_s1_addr))
        else $error("line-store read collides with the pending write");

    a_window_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && s3_valid && s3_meta.win) |=> r_out_valid)
        else $error("full window lost before the output register");

    a_edge_gives_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && !(s3_valid && s3_meta.win)) |=> !r_out_valid)
        else $error("result word invented without a full window");

endmodule
`default_nettype wire
